// File: rtl/core/priority_sorted_key_table_core_macros.svh
// Assertion macros used by the priority sorted key table top level.
`ifndef PRIORITY_SORTED_KEY_TABLE_CORE_MACROS_SVH
`define PRIORITY_SORTED_KEY_TABLE_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PSKTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psktc: invariant violated");

// Same-cycle implication.
`define PSKTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psktc: implication violated");

// Next-cycle implication.
`define PSKTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psktc: next-cycle implication violated");

`endif

// File: rtl/core/psktc_pkg.sv
// Types and constants of the priority sorted key table.
package psktc_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned OCC_W       = 4;
  localparam int unsigned READOUT_MAX = 8;
  localparam int unsigned RD_W        = $clog2(READOUT_MAX);
  localparam int unsigned SHOWN_W     = RD_W + 1;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_UPDATE  = 2'd2,
    MODE_REFRESH = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [KEY_W-1:0]  entry_key;
    logic [PRIO_W-1:0] entry_priority;
  } in_word_t;

  typedef struct packed {
    logic              changed;
    logic [OCC_W-1:0]  occupancy;
    logic              slot_valid;
    logic [KEY_W-1:0]  slot_key;
    logic [PRIO_W-1:0] slot_priority;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FIND,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
    logic     ties_before;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REMOVE,
    ST_INSERT,
    ST_READ
  } state_e;

endpackage

// File: rtl/core/psktc_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbours.
module psktc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psktc_pkg::cell_cmd_t cmd_i,
  input  logic                 slot_valid_i,
  input  logic                 seen_left_i,
  output logic                 seen_o,
  input  logic                 before_left_i,
  output logic                 before_o,
  input  psktc_pkg::entry_t    left_i,
  input  psktc_pkg::entry_t    right_i,
  output psktc_pkg::entry_t    ent_o
);

  psktc_pkg::entry_t ent_q, ent_d;
  logic              seen_q, seen_d;
  logic              hit;
  logic              tie;

  assign hit    = slot_valid_i && (ent_q.key == cmd_i.ent.key);
  // Match at this slot or anywhere to the left.
  assign seen_o = seen_left_i | hit;

  // An equal priority stays ahead of the new entry unless it sat behind the
  // updated one.
  assign tie      = cmd_i.ties_before | ~seen_q;
  assign before_o = slot_valid_i &&
                    ((ent_q.prio < cmd_i.ent.prio) ||
                     ((ent_q.prio == cmd_i.ent.prio) && tie));

  always_comb begin
    seen_d = seen_q;
    ent_d  = ent_q;
    unique case (cmd_i.op)
      psktc_pkg::CELL_HOLD: begin
        ent_d = ent_q;
      end
      psktc_pkg::CELL_FIND: begin
        seen_d = seen_o;
      end
      psktc_pkg::CELL_REMOVE: begin
        // close the gap: everything from the match on takes its right neighbour
        if (seen_q) begin
          ent_d = right_i;
        end
      end
      psktc_pkg::CELL_INSERT: begin
        if (before_o) begin
          ent_d = ent_q;
        end else if (before_left_i) begin
          ent_d = cmd_i.ent;
        end else begin
          ent_d = left_i;
        end
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// File: rtl/core/priority_sorted_key_table_core.sv
// Top level of the priority sorted key table: control, cell row and readout.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | into core | in_valid_i / in_stall_o  | in_word_i  (mode, key, priority)
//   out     | from core | out_valid_o / out_stall_i| out_word_o (one sorted table slot)
//
// One operation runs through these steps: the idle state accepts the word, one
// key search across the cell row, up to two edit passes (close gap, open gap),
// then the readout words, at most eight, each loaded when the output register frees.
// The readout rate is set by the single output register; a stall holds the
// readout where it is and the input stays stalled until the last word has been
// loaded into the output register, so the next word may be taken while it waits.
// Reset empties the table at once; the slot contents are not cleared.
`include "priority_sorted_key_table_core_macros.svh"

module priority_sorted_key_table_core #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  psktc_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output psktc_pkg::out_word_t out_word_o
);

  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CXW = (CW > psktc_pkg::SHOWN_W) ? CW : psktc_pkg::SHOWN_W;

  psktc_pkg::state_e    state_q, state_d;
  psktc_pkg::in_word_t  op_q;
  logic                 changed_q, changed_d;
  logic [CW-1:0]        count_q, count_d;
  logic [psktc_pkg::RD_W-1:0] rd_cnt_q, rd_cnt_d;
  logic                 out_valid_q;
  psktc_pkg::out_word_t out_word_q, out_word_d;

  psktc_pkg::cell_cmd_t cell_cmd;
  psktc_pkg::entry_t    ent     [MAX_ENTRIES];
  psktc_pkg::entry_t    left_e  [MAX_ENTRIES];
  psktc_pkg::entry_t    right_e [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] slot_valid;
  logic [MAX_ENTRIES-1:0] seen_vec;
  logic [MAX_ENTRIES-1:0] before_vec;
  logic [MAX_ENTRIES-1:0] seen_left;
  logic [MAX_ENTRIES-1:0] before_left;

  logic                 in_accept;
  logic                 hit;
  logic                 full;
  logic                 rd_load;
  logic                 rd_last;
  logic [CXW-1:0]       count_ext;
  logic [psktc_pkg::SHOWN_W-1:0] shown;
  logic [IW-1:0]        rd_idx;
  logic                 edit_pass;
  logic                 empty_word;

  // ---------------------------------------------------------------------------
  // Cell row. Search and gap-finding flags ripple from slot 0 to the end;
  // entries move one slot left or right per edit pass.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign slot_valid[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign seen_left[i]   = 1'b0;
      assign before_left[i] = 1'b1;
      assign left_e[i]      = '0;
    end else begin : g_body
      assign seen_left[i]   = seen_vec[i-1];
      assign before_left[i] = before_vec[i-1];
      assign left_e[i]      = ent[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_e[i] = '0;
    end else begin : g_inner
      assign right_e[i] = ent[i+1];
    end

    psktc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cell_cmd),
      .slot_valid_i (slot_valid[i]),
      .seen_left_i  (seen_left[i]),
      .seen_o       (seen_vec[i]),
      .before_left_i(before_left[i]),
      .before_o     (before_vec[i]),
      .left_i       (left_e[i]),
      .right_i      (right_e[i]),
      .ent_o        (ent[i])
    );
  end

  assign hit       = seen_vec[MAX_ENTRIES-1];
  assign full      = (count_q == CW'(MAX_ENTRIES));
  assign in_accept = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psktc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = psktc_pkg::ST_FIND;
        end
      end
      psktc_pkg::ST_FIND: begin
        priority if (hit && ((op_q.mode == psktc_pkg::MODE_REMOVE) ||
                             (op_q.mode == psktc_pkg::MODE_UPDATE))) begin
          state_d = psktc_pkg::ST_REMOVE;
        end else if (!hit && !full && (op_q.mode == psktc_pkg::MODE_ADD)) begin
          state_d = psktc_pkg::ST_INSERT;
        end else begin
          state_d = psktc_pkg::ST_READ;
        end
      end
      psktc_pkg::ST_REMOVE: begin
        if (op_q.mode == psktc_pkg::MODE_UPDATE) begin
          state_d = psktc_pkg::ST_INSERT;
        end else begin
          state_d = psktc_pkg::ST_READ;
        end
      end
      psktc_pkg::ST_INSERT: begin
        state_d = psktc_pkg::ST_READ;
      end
      psktc_pkg::ST_READ: begin
        if (rd_load && rd_last) begin
          state_d = psktc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psktc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State outputs: cell command, stall, readout load
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_cmd.op          = psktc_pkg::CELL_HOLD;
    cell_cmd.ent.key     = op_q.entry_key;
    cell_cmd.ent.prio    = op_q.entry_priority;
    // a fresh add goes behind every equal priority
    cell_cmd.ties_before = (op_q.mode == psktc_pkg::MODE_ADD);
    in_stall_o           = 1'b1;
    rd_load              = 1'b0;
    unique case (state_q)
      psktc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      psktc_pkg::ST_FIND: begin
        cell_cmd.op = psktc_pkg::CELL_FIND;
      end
      psktc_pkg::ST_REMOVE: begin
        cell_cmd.op = psktc_pkg::CELL_REMOVE;
      end
      psktc_pkg::ST_INSERT: begin
        cell_cmd.op = psktc_pkg::CELL_INSERT;
      end
      psktc_pkg::ST_READ: begin
        // load when the output register is empty or being drained
        rd_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    changed_d = changed_q;
    count_d   = count_q;
    rd_cnt_d  = rd_cnt_q;
    if (state_q == psktc_pkg::ST_FIND) begin
      rd_cnt_d = '0;
      unique case (op_q.mode)
        psktc_pkg::MODE_ADD:     changed_d = !hit;
        psktc_pkg::MODE_REMOVE:  changed_d = hit;
        psktc_pkg::MODE_UPDATE:  changed_d = hit;
        psktc_pkg::MODE_REFRESH: changed_d = 1'b1;
        default:                 changed_d = 1'b0;
      endcase
    end
    if (state_q == psktc_pkg::ST_REMOVE) begin
      count_d = count_q - CW'(1);
    end
    if (state_q == psktc_pkg::ST_INSERT) begin
      count_d = count_q + CW'(1);
    end
    if (rd_load) begin
      rd_cnt_d = rd_cnt_q + psktc_pkg::RD_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Readout word
  // ---------------------------------------------------------------------------
  assign count_ext = CXW'(count_q);
  assign shown     = (count_ext >= CXW'(psktc_pkg::READOUT_MAX)) ?
                     psktc_pkg::SHOWN_W'(psktc_pkg::READOUT_MAX) :
                     psktc_pkg::SHOWN_W'(count_ext);
  assign rd_last   = (count_q == '0) ||
                     ((psktc_pkg::SHOWN_W'(rd_cnt_q) + psktc_pkg::SHOWN_W'(1)) == shown);
  assign rd_idx    = IW'(rd_cnt_q);

  always_comb begin
    out_word_d.changed   = changed_q;
    out_word_d.occupancy = psktc_pkg::OCC_W'(count_ext);
    out_word_d.last      = rd_last;
    if (count_q == '0) begin
      out_word_d.slot_valid    = 1'b0;
      out_word_d.slot_key      = '0;
      out_word_d.slot_priority = '0;
    end else begin
      out_word_d.slot_valid    = 1'b1;
      out_word_d.slot_key      = ent[rd_idx].key;
      out_word_d.slot_priority = ent[rd_idx].prio;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psktc_pkg::ST_IDLE;
      changed_q   <= 1'b0;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      changed_q <= changed_d;
      count_q   <= count_d;
      rd_cnt_q  <= rd_cnt_d;
      if (rd_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold the operation word and the output word without reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= in_word_i;
    end
    if (rd_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assign edit_pass  = (state_q == psktc_pkg::ST_REMOVE) || (state_q == psktc_pkg::ST_INSERT);
  assign empty_word = out_valid_o && !out_word_o.slot_valid;

  `PSKTC_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_ENTRIES))
  `PSKTC_ASSERT_NEXT(a_count_only_in_edit, !edit_pass, $stable(count_q))
  `PSKTC_ASSERT_NEXT(a_last_word_ends_run, rd_load && rd_last, state_q == psktc_pkg::ST_IDLE)
  `PSKTC_ASSERT_IMPL(a_empty_word_alone, empty_word, out_word_o.last && (out_word_o.occupancy == '0))

endmodule

// File: test/tb_priority_sorted_key_table_core.sv
// Testbench for the priority sorted key table core: directed and random traffic with a slot-word scoreboard.
`timescale 1ns / 1ps

// Keeps its own copy of the sorted table and the slot words each operation reads out.
class slot_checker #(int unsigned DEPTH = 8);
  logic [psktc_pkg::KEY_W-1:0]  key_tbl[DEPTH];
  logic [psktc_pkg::PRIO_W-1:0] prio_tbl[DEPTH];
  int unsigned                  count;
  psktc_pkg::out_word_t         expected_slots[$];
  int unsigned                  mismatches;

  function new();
    count      = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return expected_slots.size();
  endfunction

  // Stable insertion sort by ascending priority.
  function void restable();
    int                           j;
    logic [psktc_pkg::KEY_W-1:0]  k;
    logic [psktc_pkg::PRIO_W-1:0] p;
    for (int i = 1; i < int'(count); i++) begin
      k = key_tbl[i];
      p = prio_tbl[i];
      j = i;
      while (j > 0 && prio_tbl[j-1] > p) begin
        key_tbl[j]  = key_tbl[j-1];
        prio_tbl[j] = prio_tbl[j-1];
        j--;
      end
      key_tbl[j]  = k;
      prio_tbl[j] = p;
    end
  endfunction

  // Apply one accepted operation and queue the slot words it reads out.
  function void note_operation(psktc_pkg::in_word_t w);
    int unsigned          hit;
    int unsigned          kept;
    int unsigned          shown;
    logic                 changed;
    psktc_pkg::out_word_t slot;
    changed = 1'b0;
    hit     = count;
    for (int unsigned i = 0; i < count; i++) begin
      if (hit == count && key_tbl[i] == w.entry_key) hit = i;
    end
    case (w.mode)
      psktc_pkg::MODE_ADD: begin
        if (hit < count) begin
          changed = 1'b0;
        end else if (count >= DEPTH) begin
          changed = 1'b1;
        end else begin
          key_tbl[count]  = w.entry_key;
          prio_tbl[count] = w.entry_priority;
          count++;
          restable();
          changed = 1'b1;
        end
      end
      psktc_pkg::MODE_REMOVE: begin
        kept = 0;
        for (int unsigned i = 0; i < count; i++) begin
          if (key_tbl[i] != w.entry_key) begin
            key_tbl[kept]  = key_tbl[i];
            prio_tbl[kept] = prio_tbl[i];
            kept++;
          end
        end
        if (kept != count) begin
          count = kept;
          restable();
          changed = 1'b1;
        end
      end
      psktc_pkg::MODE_UPDATE: begin
        if (hit < count) begin
          prio_tbl[hit] = w.entry_priority;
          restable();
          changed = 1'b1;
        end
      end
      default: begin
        restable();
        changed = 1'b1;
      end
    endcase

    if (count == 0) begin
      slot            = '0;
      slot.changed    = changed;
      slot.last       = 1'b1;
      expected_slots  = {expected_slots, slot};
    end else begin
      shown = (count < psktc_pkg::READOUT_MAX) ? count : psktc_pkg::READOUT_MAX;
      for (int unsigned i = 0; i < shown; i++) begin
        slot.changed       = changed;
        slot.occupancy     = count[psktc_pkg::OCC_W-1:0];
        slot.slot_valid    = 1'b1;
        slot.slot_key      = key_tbl[i];
        slot.slot_priority = prio_tbl[i];
        slot.last          = (i + 1 == shown);
        expected_slots     = {expected_slots, slot};
      end
    end
  endfunction

  // Compare a slot word that left the core with the oldest one waiting.
  function void check_slot(psktc_pkg::out_word_t got);
    psktc_pkg::out_word_t want;
    if (expected_slots.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected slot word: key %h prio %0d last %0b",
                 got.slot_key, got.slot_priority, got.last);
      return;
    end
    want = expected_slots.pop_front();
    if (got.changed !== want.changed || got.occupancy !== want.occupancy ||
        got.slot_valid !== want.slot_valid || got.slot_key !== want.slot_key ||
        got.slot_priority !== want.slot_priority || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("slot word mismatch, want: chg %0b occ %0d vld %0b key %h prio %0d last %0b",
                 want.changed, want.occupancy, want.slot_valid, want.slot_key,
                 want.slot_priority, want.last);
        $display("                     got: chg %0b occ %0d vld %0b key %h prio %0d last %0b",
                 got.changed, got.occupancy, got.slot_valid, got.slot_key,
                 got.slot_priority, got.last);
      end
    end
  endfunction
endclass

module tb_priority_sorted_key_table_core;

  localparam int unsigned KEY_W       = psktc_pkg::KEY_W;
  localparam int unsigned PRIO_W      = psktc_pkg::PRIO_W;
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned EPISODES    = 5;
  localparam int unsigned EPISODE_LEN = 22;
  localparam int unsigned POOL_SIZE   = 10;
  localparam int unsigned TAIL_CYCLES = 16;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  psktc_pkg::in_word_t  in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  psktc_pkg::out_word_t out_word_o;

  // Upper bounds of the idle draws; changed per phase so that some stretches run flat out.
  int unsigned send_gap_max    = 6;
  int unsigned drain_stall_max = 6;

  slot_checker #(TABLE_DEPTH) sb;
  logic [KEY_W-1:0]           key_pool[POOL_SIZE];

  priority_sorted_key_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watch both channels at the edge; values read here are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_operation(in_word_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_slot(out_word_o);
  end

  // Receiver: stall for a drawn number of cycles, then take one slot word.
  initial begin
    int unsigned hold;
    forever begin
      hold = $urandom_range(0, drain_stall_max);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_ni && out_valid_o && !out_stall_i));
    end
  end

  // Offer one operation word after a drawn gap and hold it until the core takes it.
  task automatic send_op(input psktc_pkg::mode_e m, input logic [KEY_W-1:0] k,
                         input logic [PRIO_W-1:0] p);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{mode: m, entry_key: k, entry_priority: p};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every queued slot word has arrived.
  task automatic hold_until_drained(input int unsigned tail);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom(), $urandom()};
  endfunction

  // Favour a few low priorities and the top one so that ties turn up often.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return PRIO_W'($urandom_range(0, 3));
    if (r < 55) return '1;
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  // Mostly keys from the pool or the table so that hits, duplicates and full adds occur.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 85 && sb.count != 0) return sb.key_tbl[$urandom_range(0, sb.count - 1)];
    return any_key();
  endfunction

  function automatic psktc_pkg::mode_e pick_mode(input int unsigned remove_share);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < remove_share) return psktc_pkg::MODE_REMOVE;
    if (r < remove_share + 25) return psktc_pkg::MODE_UPDATE;
    if (r < remove_share + 40) return psktc_pkg::MODE_REFRESH;
    return psktc_pkg::MODE_ADD;
  endfunction

  initial begin
    logic [KEY_W-1:0] key_a, key_b, key_c, key_d, key_e, key_f, key_g;
    int unsigned      remove_share;
    sb = new();
    key_a = any_key();
    key_b = any_key();
    key_c = any_key();
    key_d = any_key();
    key_e = any_key();
    key_f = any_key();
    key_g = any_key();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: refresh reports a change, remove and update of an absent key do not.
    send_op(psktc_pkg::MODE_REFRESH, '0, '0);
    send_op(psktc_pkg::MODE_REMOVE, '0, '0);
    send_op(psktc_pkg::MODE_UPDATE, '0, '1);
    // Fill to the brim with key and priority extremes, ties and a duplicate.
    send_op(psktc_pkg::MODE_ADD, '0, '1);
    send_op(psktc_pkg::MODE_ADD, '1, '0);
    send_op(psktc_pkg::MODE_ADD, '0, 8'd7);
    send_op(psktc_pkg::MODE_ADD, key_a, 8'd0);
    send_op(psktc_pkg::MODE_ADD, key_b, 8'd128);
    send_op(psktc_pkg::MODE_ADD, key_c, 8'd128);
    send_op(psktc_pkg::MODE_ADD, key_d, '1);
    send_op(psktc_pkg::MODE_ADD, key_e, 8'd1);
    send_op(psktc_pkg::MODE_ADD, key_f, 8'd64);
    // Full table: a new key is refused with a change, a duplicate without one.
    send_op(psktc_pkg::MODE_ADD, key_g, 8'd3);
    send_op(psktc_pkg::MODE_ADD, key_b, 8'd9);
    // Updates: move ahead into a tie, keep the same priority, miss, refresh, then move another key into a tie.
    send_op(psktc_pkg::MODE_UPDATE, key_c, 8'd0);
    send_op(psktc_pkg::MODE_UPDATE, key_b, 8'd128);
    send_op(psktc_pkg::MODE_UPDATE, key_g, 8'd5);
    send_op(psktc_pkg::MODE_REFRESH, key_g, 8'd5);
    send_op(psktc_pkg::MODE_UPDATE, '0, '0);
    // Removes: present, absent, present, then move one entry to the back.
    send_op(psktc_pkg::MODE_REMOVE, key_a, '0);
    send_op(psktc_pkg::MODE_REMOVE, key_g, '0);
    send_op(psktc_pkg::MODE_REMOVE, '1, '0);
    send_op(psktc_pkg::MODE_UPDATE, key_e, '1);
    hold_until_drained(TAIL_CYCLES);

    // Random episodes, each with a fresh key pool and one of three idling profiles.
    for (int unsigned ep = 0; ep < EPISODES; ep++) begin
      foreach (key_pool[i]) key_pool[i] = any_key();
      case (ep % 3)
        0: begin
          send_gap_max    = 6;
          drain_stall_max = 6;
        end
        1: begin
          send_gap_max    = 0;
          drain_stall_max = 0;
        end
        default: begin
          send_gap_max    = 6;
          drain_stall_max = 0;
        end
      endcase
      // Lean towards removes in one episode so the table empties now and then.
      remove_share = (ep == 3) ? 45 : 20;
      for (int unsigned n = 0; n < EPISODE_LEN; n++) begin
        send_op(pick_mode(remove_share), pick_key(), pick_prio());
      end
      hold_until_drained(TAIL_CYCLES);
    end

    // Allow any stray word to surface before the verdict.
    hold_until_drained(TAIL_CYCLES + 8);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/psktc_pkg.sv
rtl/core/psktc_cell.sv
rtl/core/priority_sorted_key_table_core.sv
test/tb_priority_sorted_key_table_core.sv
